[rtl/core/art_pkg.sv]
// -----------------------------------------------------------------------------
// art_pkg
// Shared types and constants for the anchor range table: item codes, result
// status codes, the per-entry record and the control word sent to each cell.
// -----------------------------------------------------------------------------
`default_nettype none

package art_pkg;

   // Default number of table entries
   localparam int DEFAULT_DEPTH = 16;

   // Item function codes
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_UPDATE = 2'd1;
   localparam logic [1:0] FUNC_DELETE = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_ZERO    = 2'd3;

   // Field widths
   localparam int KEY_W   = 16;
   localparam int RANGE_W = 24;
   localparam int LEVEL_W = 16;

   // Reciprocal of three, scaled by 2^33 and rounded up: exact for n < 2^32
   localparam logic [31:0] RECIP_THREE = 32'hAAAA_AAAB;
   localparam int          RECIP_SHIFT = 33;

   // One table entry
   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic signed [RANGE_W-1:0] newest;
      logic signed [RANGE_W-1:0] previous;
      logic signed [LEVEL_W-1:0] level;
   } entry_type;

   // Broadcast control to every cell
   typedef struct packed {
      logic lookup;
      logic insert;
      logic update;
      logic remove;
   } cell_ctl_type;

endpackage

`default_nettype wire

[rtl/core/art_cell.sv]
// -----------------------------------------------------------------------------
// art_cell
// One table entry. Compares its key against the broadcast key, marks itself
// as the earliest match through the chain, and loads, updates or takes its
// neighbor's entry when the sequencer commits an item.
// -----------------------------------------------------------------------------
`default_nettype none

module art_cell #(
   parameter int Index  = 0,
   parameter int CountW = 5
) (
   input  wire logic                                clock,
   input  wire art_pkg::cell_ctl_type               ctl,
   input  wire logic [art_pkg::KEY_W-1:0]           key_in,
   input  wire logic [CountW-1:0]                   count_in,
   input  wire logic signed [art_pkg::RANGE_W-1:0]  avg_in,
   input  wire logic signed [art_pkg::LEVEL_W-1:0]  level_in,
   input  wire logic                                seen_in,
   output logic                                     seen_out,
   input  wire art_pkg::entry_type                  next_in,
   output art_pkg::entry_type                       entry_out,
   output logic signed [art_pkg::RANGE_W-1:0]       sel_newest,
   output logic signed [art_pkg::RANGE_W-1:0]       sel_previous
);

   art_pkg::entry_type entry_ff;
   logic               first_ff;
   logic               shift_ff;
   logic               occupied;
   logic               hit;
   logic               at_tail;

   // Match only entries that are in use
   assign occupied = CountW'(Index) < count_in;
   assign at_tail  = CountW'(Index) == count_in;
   assign hit      = occupied && (entry_ff.key == key_in);
   assign seen_out = seen_in | hit;

   // Latch match position during lookup
   always_ff @(posedge clock) begin
      if (ctl.lookup) begin
         first_ff <= hit & ~seen_in;
         shift_ff <= seen_in | hit;
      end
   end

   // Apply the committed operation
   always_ff @(posedge clock) begin
      if (ctl.insert && at_tail) begin
         entry_ff.key      <= key_in;
         entry_ff.newest   <= '0;
         entry_ff.previous <= '0;
         entry_ff.level    <= '0;
      end else if (ctl.update && first_ff) begin
         entry_ff.previous <= entry_ff.newest;
         entry_ff.newest   <= avg_in;
         entry_ff.level    <= level_in;
      end else if (ctl.remove && shift_ff) begin
         entry_ff <= next_in;
      end
   end

   assign entry_out    = entry_ff;
   assign sel_newest   = first_ff ? entry_ff.newest : '0;
   assign sel_previous = first_ff ? entry_ff.previous : '0;

endmodule

`default_nettype wire

[rtl/core/anchor_range_table.sv]
// -----------------------------------------------------------------------------
// anchor_range_table
// Ordered table of anchors keyed by address, with a three-point range average.
// -----------------------------------------------------------------------------
// Each item passes these steps on its way to the result register: taking the
// item, the parallel key compare along the row of cells, gathering the matched
// entry and forming the sum, and the divide by three (a reciprocal multiply)
// with the write back into the cells, which waits while a held result is
// stalled. A new item is taken in the cycle after the write back, while the
// previous result may still wait in the output register. Delete shifts every
// later entry up by one place in that same write-back cycle.
`default_nettype none

module anchor_range_table #(
   parameter int Depth = art_pkg::DEFAULT_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_func,
   input  wire logic [15:0]                         req_anchor_id,
   input  wire logic signed [23:0]                  req_range_sample,
   input  wire logic signed [15:0]                  req_level_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [1:0]                               rsp_status,
   output logic signed [23:0]                       rsp_smoothed_range,
   output logic signed [15:0]                       rsp_stored_level,
   output logic [4:0]                               rsp_entry_count
);

   localparam int CountW = $clog2(Depth + 1);
   localparam int SumW   = art_pkg::RANGE_W + 2;
   localparam int AbsW   = art_pkg::RANGE_W + 1;
   localparam int ProdW  = AbsW + 32;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_SUM    = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [CountW-1:0]           count_ff, count_in;
   logic [1:0]                  func_ff;
   logic [15:0]                 key_ff;
   logic signed [23:0]          sample_ff;
   logic signed [15:0]          level_ff;
   logic                        found_ff;
   logic                        neg_ff;
   logic [AbsW-1:0]             abs_ff;

   logic                        rsp_valid_ff;
   logic [1:0]                  status_ff, status_in;
   logic signed [23:0]          range_ff, range_in;
   logic signed [15:0]          outlvl_ff, outlvl_in;

   art_pkg::cell_ctl_type       ctl;
   art_pkg::entry_type          cell_entry [Depth];
   logic signed [23:0]          cell_newest [Depth];
   logic signed [23:0]          cell_prev [Depth];
   logic                        seen [Depth+1];
   logic signed [23:0]          sel_newest, sel_prev;
   logic signed [SumW-1:0]      sum;
   logic [ProdW-1:0]            product;
   logic [23:0]                 quot;
   logic signed [23:0]          avg;
   logic                        accept;
   logic                        commit;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign commit    = (state_ff == ST_COMMIT) && (!rsp_valid_ff || !rsp_stall);

   // Build the row of cells
   assign seen[0] = 1'b0;
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      art_pkg::entry_type nbr;
      if (i == Depth - 1) begin : g_last
         assign nbr = cell_entry[i];
      end else begin : g_mid
         assign nbr = cell_entry[i+1];
      end
      art_cell #(
         .Index  (i),
         .CountW (CountW)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .key_in       (key_ff),
         .count_in     (count_ff),
         .avg_in       (avg),
         .level_in     (level_ff),
         .seen_in      (seen[i]),
         .seen_out     (seen[i+1]),
         .next_in      (nbr),
         .entry_out    (cell_entry[i]),
         .sel_newest   (cell_newest[i]),
         .sel_previous (cell_prev[i])
      );
   end

   // Gather the matched entry's history
   always_comb begin
      sel_newest = '0;
      sel_prev   = '0;
      for (int i = 0; i < Depth; i++) begin
         sel_newest = sel_newest | cell_newest[i];
         sel_prev   = sel_prev | cell_prev[i];
      end
   end

   // Three-point sum and divide by three, truncated toward zero
   assign sum     = SumW'(sample_ff) + SumW'(sel_newest) + SumW'(sel_prev);
   assign product = ProdW'(abs_ff) * ProdW'(art_pkg::RECIP_THREE);
   assign quot    = product[art_pkg::RECIP_SHIFT +: 24];
   assign avg     = neg_ff ? -$signed(quot) : $signed(quot);

   // Decide the operation and result at commit
   always_comb begin
      ctl        = '0;
      ctl.lookup = state_ff == ST_LOOKUP;
      count_in   = count_ff;
      status_in  = art_pkg::STATUS_DONE;
      range_in   = '0;
      outlvl_in  = '0;
      case (func_ff)
         art_pkg::FUNC_INSERT: begin
            if (count_ff == CountW'(Depth)) begin
               status_in = art_pkg::STATUS_FULL;
            end else begin
               ctl.insert = commit;
               count_in   = count_ff + 1'b1;
            end
         end
         art_pkg::FUNC_UPDATE: begin
            if (key_ff == '0) begin
               status_in = art_pkg::STATUS_ZERO;
            end else if (!found_ff) begin
               status_in = art_pkg::STATUS_MISSING;
            end else begin
               ctl.update = commit;
               range_in   = avg;
               outlvl_in  = level_ff;
            end
         end
         art_pkg::FUNC_DELETE: begin
            if (key_ff == '0) begin
               status_in = art_pkg::STATUS_ZERO;
            end else if (!found_ff) begin
               status_in = art_pkg::STATUS_MISSING;
            end else begin
               ctl.remove = commit;
               count_in   = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = art_pkg::STATUS_DONE;
         end
      endcase
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_SUM;
         ST_SUM:    state_in = ST_COMMIT;
         ST_COMMIT: if (commit) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the item and intermediate values
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func;
         key_ff    <= req_anchor_id;
         sample_ff <= req_range_sample;
         level_ff  <= req_level_sample;
      end
      if (state_ff == ST_LOOKUP) begin
         found_ff <= seen[Depth];
      end
      if (state_ff == ST_SUM) begin
         neg_ff <= sum[SumW-1];
         abs_ff <= sum[SumW-1] ? AbsW'(-sum) : AbsW'(sum);
      end
      if (commit) begin
         status_ff <= status_in;
         range_ff  <= range_in;
         outlvl_ff <= outlvl_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_smoothed_range = range_ff;
   assign rsp_stored_level   = outlvl_ff;
   assign rsp_entry_count    = 5'(count_ff);

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for anchor_range_table. A scoreboard class keeps its own
// copy of the anchor table, predicts the result of every accepted item and
// checks each result field by field in order. Stimulus is a directed pass over
// the edge cases followed by weighted random phases with random idling on both
// channels.
// -----------------------------------------------------------------------------

typedef struct packed {
   logic [1:0]         status;
   logic signed [23:0] smoothed;
   logic signed [15:0] level;
   logic [4:0]         count;
} table_result_type;

class anchor_table_board;
   logic [15:0]        keys [art_pkg::DEFAULT_DEPTH];
   int                 newest [art_pkg::DEFAULT_DEPTH];
   int                 previous [art_pkg::DEFAULT_DEPTH];
   logic signed [15:0] levels [art_pkg::DEFAULT_DEPTH];
   int                 held;
   table_result_type   awaited [$];
   int                 mismatches;

   function new();
      held = 0;
      mismatches = 0;
   endfunction

   function int pending();
      return awaited.size();
   endfunction

   // Earliest slot holding this key, or -1
   function int find_key(logic [15:0] key);
      for (int i = 0; i < held; i++) begin
         if (keys[i] == key) return i;
      end
      return -1;
   endfunction

   // Apply one accepted item to the table copy and queue its result
   function void note_item(logic [1:0] func, logic [15:0] key,
                           logic signed [23:0] sample, logic signed [15:0] level);
      table_result_type res;
      int slot;
      int total;
      res = '0;
      res.status = art_pkg::STATUS_DONE;
      slot = find_key(key);
      case (func)
         art_pkg::FUNC_INSERT: begin
            if (held >= art_pkg::DEFAULT_DEPTH) begin
               res.status = art_pkg::STATUS_FULL;
            end else begin
               keys[held] = key;
               newest[held] = 0;
               previous[held] = 0;
               levels[held] = '0;
               held++;
            end
         end
         art_pkg::FUNC_UPDATE: begin
            if (key == 16'h0000) begin
               res.status = art_pkg::STATUS_ZERO;
            end else if (slot < 0) begin
               res.status = art_pkg::STATUS_MISSING;
            end else begin
               // three-point average, truncated toward zero
               total = int'(sample) + newest[slot] + previous[slot];
               previous[slot] = newest[slot];
               newest[slot] = total / 3;
               levels[slot] = level;
               res.smoothed = newest[slot];
               res.level = level;
            end
         end
         art_pkg::FUNC_DELETE: begin
            if (key == 16'h0000) begin
               res.status = art_pkg::STATUS_ZERO;
            end else if (slot < 0) begin
               res.status = art_pkg::STATUS_MISSING;
            end else begin
               // close the gap
               for (int i = slot; i + 1 < held; i++) begin
                  keys[i] = keys[i + 1];
                  newest[i] = newest[i + 1];
                  previous[i] = previous[i + 1];
                  levels[i] = levels[i + 1];
               end
               held--;
            end
         end
         default: ;
      endcase
      res.count = held[4:0];
      awaited.push_back(res);
   endfunction

   // Compare one result with the oldest prediction
   function void check_result(logic [1:0] status, logic signed [23:0] smoothed,
                              logic signed [15:0] level, logic [4:0] count);
      table_result_type want;
      if (awaited.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected result: status %0d range %0d level %0d count %0d",
                     $realtime, status, smoothed, level, count);
         return;
      end
      want = awaited.pop_front();
      if (status !== want.status || smoothed !== want.smoothed ||
          level !== want.level || count !== want.count) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch: expected status %0d range %0d level %0d count %0d,",
                     $realtime, want.status, want.smoothed, want.level, want.count,
                     " got status %0d range %0d level %0d count %0d",
                     status, smoothed, level, count);
      end
   endfunction
endclass

module testbench;

   localparam logic [1:0]         FUNC_UNUSED = 2'd3;
   localparam logic signed [23:0] RANGE_MAX   = 24'sh7FFFFF;
   localparam logic signed [23:0] RANGE_MIN   = 24'sh800000;
   localparam logic signed [15:0] LEVEL_MAX   = 16'sh7FFF;
   localparam logic signed [15:0] LEVEL_MIN   = 16'sh8000;
   localparam int                 CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = '0;
   logic [15:0]        req_anchor_id = '0;
   logic signed [23:0] req_range_sample = '0;
   logic signed [15:0] req_level_sample = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [23:0] rsp_smoothed_range;
   logic signed [15:0] rsp_stored_level;
   logic [4:0]         rsp_entry_count;

   bit                 calm = 1'b0;
   int                 cycles = 0;
   logic [15:0]        key_pool [8];
   anchor_table_board  board;

   anchor_range_table u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_anchor_id      (req_anchor_id),
      .req_range_sample   (req_range_sample),
      .req_level_sample   (req_level_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_smoothed_range (rsp_smoothed_range),
      .rsp_stored_level   (rsp_stored_level),
      .rsp_entry_count    (rsp_entry_count)
   );

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_status, rsp_smoothed_range, rsp_stored_level,
                            rsp_entry_count);
   end

   // Stall the result channel in random bursts, none once calm
   initial begin : stall_gen
      int span;
      forever begin
         span = $urandom_range(1, 14);
         if (!calm && $urandom_range(0, 2) == 0)
            rsp_stall <= 1'b1;
         else
            rsp_stall <= 1'b0;
         repeat (span) @(posedge clock);
      end
   end

   // Drop valid and hold for a number of cycles
   task automatic pause(int span);
      req_valid <= 1'b0;
      repeat (span) @(posedge clock);
   endtask

   // Present one item, wait for it to be taken, then maybe idle
   task automatic send_item(logic [1:0] func, logic [15:0] key,
                            logic signed [23:0] sample, logic signed [15:0] level);
      req_valid <= 1'b1;
      req_func <= func;
      req_anchor_id <= key;
      req_range_sample <= sample;
      req_level_sample <= level;
      do @(posedge clock); while (req_stall);
      board.note_item(func, key, sample, level);
      if (!calm && $urandom_range(0, 3) == 0)
         pause($urandom_range(1, 14));
   endtask

   // Run a phase of weighted random items over a small key pool
   task automatic random_phase(int items, int w_ins, int w_upd, int w_del);
      logic [1:0]         func;
      logic [15:0]        key;
      logic signed [23:0] sample;
      logic signed [15:0] level;
      int                 pick;
      foreach (key_pool[i]) key_pool[i] = 16'($urandom_range(1, 65535));
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < w_ins) func = art_pkg::FUNC_INSERT;
         else if (pick < w_ins + w_upd) func = art_pkg::FUNC_UPDATE;
         else if (pick < w_ins + w_upd + w_del) func = art_pkg::FUNC_DELETE;
         else func = FUNC_UNUSED;
         pick = $urandom_range(0, 99);
         if (pick < 85) key = key_pool[$urandom_range(0, 7)];
         else if (pick < 95) key = 16'($urandom());
         else key = 16'h0000;
         case ($urandom_range(0, 9))
            0: sample = RANGE_MAX;
            1: sample = RANGE_MIN;
            2, 3: sample = 24'($urandom_range(0, 20000));
            default: sample = 24'($urandom());
         endcase
         case ($urandom_range(0, 9))
            0: level = LEVEL_MAX;
            1: level = LEVEL_MIN;
            default: level = 16'($urandom());
         endcase
         send_item(func, key, sample, level);
      end
   endtask

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: nothing to find
      send_item(art_pkg::FUNC_UPDATE, 16'h0005, 24'sd1000, 16'sd256);
      send_item(art_pkg::FUNC_DELETE, 16'h0005, 24'sd0, 16'sd0);
      // zero address is an ordinary key on insert
      send_item(art_pkg::FUNC_INSERT, 16'hFFFF, RANGE_MAX, LEVEL_MAX);
      send_item(art_pkg::FUNC_INSERT, 16'h0001, RANGE_MIN, LEVEL_MIN);
      send_item(art_pkg::FUNC_INSERT, 16'h0000, 24'sd0, 16'sd0);
      // drive the range history to both extremes
      send_item(art_pkg::FUNC_UPDATE, 16'hFFFF, RANGE_MAX, LEVEL_MAX);
      send_item(art_pkg::FUNC_UPDATE, 16'hFFFF, RANGE_MAX, LEVEL_MAX);
      send_item(art_pkg::FUNC_UPDATE, 16'hFFFF, RANGE_MIN, LEVEL_MIN);
      // zero address, unknown address, unused code
      send_item(art_pkg::FUNC_UPDATE, 16'h0000, 24'sd77, 16'sd5);
      send_item(art_pkg::FUNC_DELETE, 16'h0000, 24'sd0, 16'sd0);
      send_item(art_pkg::FUNC_UPDATE, 16'h1234, 24'sd42, 16'sd9);
      send_item(art_pkg::FUNC_DELETE, 16'h1234, 24'sd0, 16'sd0);
      send_item(FUNC_UNUSED, 16'hFFFF, RANGE_MAX, LEVEL_MAX);
      // fill the table with duplicates, then overflow it
      for (int i = 0; i < 13; i++)
         send_item(art_pkg::FUNC_INSERT, (i % 2 == 1) ? 16'h0001 : 16'hA5A5 ^ 16'(i),
                   RANGE_MAX, LEVEL_MAX);
      send_item(art_pkg::FUNC_INSERT, 16'h7777, 24'sd0, 16'sd0);
      // negative average truncates toward zero; delete the earliest duplicate
      send_item(art_pkg::FUNC_UPDATE, 16'h0001, -24'sd7, -16'sd3);
      send_item(art_pkg::FUNC_DELETE, 16'h0001, 24'sd0, 16'sd0);
      send_item(art_pkg::FUNC_DELETE, 16'hFFFF, 24'sd0, 16'sd0);

      random_phase(400, 40, 40, 17);
      random_phase(400, 20, 45, 32);

      // hold off until the table has answered everything
      pause(1);
      while (board.pending() != 0) @(posedge clock);

      random_phase(400, 30, 45, 22);
      calm = 1'b1;
      random_phase(350, 33, 40, 24);

      // drain, then allow for late or extra results
      pause(1);
      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
